/* hdl/rsag_pkg.sv */
// Shared constants, register indexes and control structs for the reverse-sequence address generator.
`timescale 1ns / 1ps

package rsag_pkg;

  localparam int MAX_RANK     = 6;
  localparam int BATCH_MAX    = 256;
  localparam int DIM_W        = 16;
  localparam int ADDR_W       = 32;

  localparam int NUM_DIM_REGS = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int SEL_W        = 3;
  localparam int BIDX_W       = 8;
  localparam int SLEN_W       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SEQ_SEL   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_SEL = 3'd7;

  localparam logic [SEL_W-1:0] SEQ_SEL_RST   = 3'd5;
  localparam logic [SEL_W-1:0] BATCH_SEL_RST = 3'd4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic clear;
    logic step;
  } rsag_cnt_ctl_t;

  typedef struct packed {
    logic             busy;
    logic [SEL_W-1:0] seq_sel;
    logic [SEL_W-1:0] batch_sel;
  } rsag_cfg_stat_t;

endpackage

/* hdl/rsag_if.sv */
// Request and result channel interfaces.
`timescale 1ns / 1ps

interface rsag_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [rsag_pkg::BIDX_W-1:0]  batch_index;
  logic [rsag_pkg::SLEN_W-1:0]  seq_length;

  modport source (output valid, output op, output batch_index, output seq_length, input ready);
  modport sink (input valid, input op, input batch_index, input seq_length, output ready);
endinterface

interface rsag_out_if #(
  parameter int ADDR_W = rsag_pkg::ADDR_W
);
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] dst_index;
  logic [ADDR_W-1:0] src_index;
  logic              last;
  logic              error;

  modport source (output valid, output dst_index, output src_index, output last, output error,
                  input ready);
  modport sink (input valid, input dst_index, input src_index, input last, input error,
                output ready);
endinterface

/* hdl/rsag_cfg.sv */
// Configuration registers and serial shift-add stride sequencer.
`timescale 1ns / 1ps

module rsag_cfg #(
  parameter int MAX_RANK = rsag_pkg::MAX_RANK,
  parameter int DIM_W    = rsag_pkg::DIM_W,
  parameter int ADDR_W   = rsag_pkg::ADDR_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rsag_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [DIM_W-1:0]                    cfg_wdata,
  output logic [MAX_RANK-1:0][DIM_W-1:0]      dims,
  output rsag_pkg::rsag_cfg_stat_t            stat,
  output logic [ADDR_W-1:0]                   seq_stride
);

  localparam int AXW = $clog2(MAX_RANK);
  localparam int BW  = $clog2(DIM_W);

  logic [MAX_RANK-1:0][DIM_W-1:0] dim_r;
  logic [rsag_pkg::SEL_W-1:0]     seq_sel_r;
  logic [rsag_pkg::SEL_W-1:0]     batch_sel_r;

  logic [ADDR_W-1:0] stride_r [MAX_RANK];
  logic              busy_r;
  logic [AXW-1:0]    axis_r;
  logic [BW-1:0]     bit_r;
  logic [ADDR_W-1:0] prod_r;
  logic [ADDR_W-1:0] acc_r;
  logic [ADDR_W-1:0] acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_RANK; i++) begin
        dim_r[i] <= DIM_W'(1);
      end
      seq_sel_r   <= rsag_pkg::SEQ_SEL_RST;
      batch_sel_r <= rsag_pkg::BATCH_SEL_RST;
    end else if (cfg_we) begin
      for (int i = 0; i < MAX_RANK; i++) begin
        if (i < rsag_pkg::NUM_DIM_REGS && cfg_index == rsag_pkg::CFG_IDX_W'(i)) begin
          // a zero size counts as one
          dim_r[i] <= (cfg_wdata == '0) ? DIM_W'(1) : cfg_wdata;
        end
      end
      if (cfg_index == rsag_pkg::REG_SEQ_SEL) begin
        seq_sel_r <= cfg_wdata[rsag_pkg::SEL_W-1:0];
      end
      if (cfg_index == rsag_pkg::REG_BATCH_SEL) begin
        batch_sel_r <= cfg_wdata[rsag_pkg::SEL_W-1:0];
      end
    end
  end

  // one multiplier bit per cycle: running product times the size of the current axis
  always_comb begin
    acc_nxt = ((bit_r == '0) ? '0 : acc_r) +
              (dim_r[axis_r][bit_r] ? (prod_r << bit_r) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      axis_r <= '0;
      bit_r  <= '0;
      prod_r <= ADDR_W'(1);
      acc_r  <= '0;
      for (int i = 0; i < MAX_RANK; i++) begin
        stride_r[i] <= ADDR_W'(1);
      end
    end else if (cfg_we) begin
      busy_r <= 1'b1;
      axis_r <= AXW'(MAX_RANK - 1);
      bit_r  <= '0;
      prod_r <= ADDR_W'(1);
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      if (bit_r == '0) begin
        stride_r[axis_r] <= prod_r;
      end
      if (bit_r == BW'(DIM_W - 1)) begin
        prod_r <= acc_nxt;
        bit_r  <= '0;
        if (axis_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          axis_r <= axis_r - 1'b1;
        end
      end else begin
        bit_r <= bit_r + 1'b1;
      end
    end
  end

  assign dims           = dim_r;
  assign stat.busy      = busy_r;
  assign stat.seq_sel   = seq_sel_r;
  assign stat.batch_sel = batch_sel_r;
  assign seq_stride     = (int'(seq_sel_r) < MAX_RANK) ? stride_r[seq_sel_r[AXW-1:0]] : '0;

endmodule

/* hdl/rsag_cnt.sv */
// Destination position counter: coordinate digits and linear index.
`timescale 1ns / 1ps

module rsag_cnt #(
  parameter int MAX_RANK = rsag_pkg::MAX_RANK,
  parameter int DIM_W    = rsag_pkg::DIM_W,
  parameter int ADDR_W   = rsag_pkg::ADDR_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rsag_pkg::rsag_cnt_ctl_t        ctl,
  input  logic [MAX_RANK-1:0][DIM_W-1:0] dims,
  output logic [MAX_RANK-1:0][DIM_W-1:0] digits,
  output logic [ADDR_W-1:0]              linear,
  output logic                           all_wrap
);

  logic [MAX_RANK-1:0][DIM_W-1:0] digit_r;
  logic [MAX_RANK-1:0][DIM_W-1:0] digit_nxt;
  logic [ADDR_W-1:0]              lin_r;
  logic [MAX_RANK-1:0]            wrap;
  logic [MAX_RANK-1:0]            carry_in;

  always_comb begin
    for (int i = 0; i < MAX_RANK; i++) begin
      wrap[i] = ({1'b0, digit_r[i]} + (DIM_W + 1)'(1)) >= {1'b0, dims[i]};
    end
    carry_in[MAX_RANK-1] = 1'b1;
    for (int i = MAX_RANK - 2; i >= 0; i--) begin
      carry_in[i] = carry_in[i+1] & wrap[i+1];
    end
    for (int i = 0; i < MAX_RANK; i++) begin
      if (carry_in[i]) begin
        digit_nxt[i] = wrap[i] ? '0 : digit_r[i] + 1'b1;
      end else begin
        digit_nxt[i] = digit_r[i];
      end
    end
    all_wrap = carry_in[0] & wrap[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      digit_r <= '0;
      lin_r   <= '0;
    end else if (ctl.step) begin
      digit_r <= digit_nxt;
      lin_r   <= all_wrap ? '0 : lin_r + 1'b1;
    end
  end

  assign digits = digit_r;
  assign linear = lin_r;

endmodule

/* hdl/rsag_len_tbl.sv */
// Per-batch sequence length memory with load check and step lookup.
`timescale 1ns / 1ps

module rsag_len_tbl #(
  parameter int MAX_RANK  = rsag_pkg::MAX_RANK,
  parameter int BATCH_MAX = rsag_pkg::BATCH_MAX,
  parameter int DIM_W     = rsag_pkg::DIM_W
) (
  input  logic                              clk,
  input  logic                              accept,
  input  logic                              op,
  input  logic [rsag_pkg::BIDX_W-1:0]       batch_index,
  input  logic [rsag_pkg::SLEN_W-1:0]       seq_length,
  input  logic [MAX_RANK-1:0][DIM_W-1:0]    dims,
  input  logic [MAX_RANK-1:0][DIM_W-1:0]    digits,
  input  rsag_pkg::rsag_cfg_stat_t          stat,
  output logic                              load_err,
  output logic [rsag_pkg::SLEN_W-1:0]       rd_len_r,
  output logic                              hit_r
);

  localparam int AXW = $clog2(MAX_RANK);
  localparam int AW  = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
  localparam int CW  = 33;

  logic [rsag_pkg::SLEN_W-1:0] mem [BATCH_MAX];

  logic             bsel_ok;
  logic             ssel_ok;
  logic [DIM_W-1:0] bcoord;
  logic [DIM_W-1:0] bat_dim;
  logic [DIM_W-1:0] seq_dim;
  logic             hit;

  always_comb begin
    bsel_ok  = int'(stat.batch_sel) < MAX_RANK;
    ssel_ok  = int'(stat.seq_sel) < MAX_RANK;
    bcoord   = bsel_ok ? digits[stat.batch_sel[AXW-1:0]] : '0;
    bat_dim  = bsel_ok ? dims[stat.batch_sel[AXW-1:0]] : '0;
    seq_dim  = ssel_ok ? dims[stat.seq_sel[AXW-1:0]] : '0;
    hit      = CW'(bcoord) < CW'(BATCH_MAX);
    load_err = (CW'(batch_index) >= CW'(BATCH_MAX)) ||
               (bsel_ok && (CW'(batch_index) >= CW'(bat_dim))) ||
               (ssel_ok && (CW'(seq_length) > CW'(seq_dim)));
  end

  always_ff @(posedge clk) begin
    if (accept && op == rsag_pkg::OP_LOAD && !load_err) begin
      mem[AW'(batch_index)] <= seq_length;
    end
    if (accept && op == rsag_pkg::OP_STEP) begin
      rd_len_r <= mem[AW'(bcoord)];
      hit_r    <= hit;
    end
  end

endmodule

/* hdl/reverse_sequence_address_gen_unit.sv */
// Top level of the reverse-sequence address generator.
`timescale 1ns / 1ps

// Takes one request per clock while in_if.ready is high and returns one result per request,
// in order, through the stage 1, stage 2, stage 3 and output registers; a stalled output
// holds off the input only once every pipeline register holds a result. A load request writes
// one entry of the length memory; a step request reads the entry chosen by the current batch
// coordinate, mirrors the sequence coordinate and forms the source index as the destination
// index plus one product of the mirror offset and the sequence-axis stride. Each configuration
// write clears the position counter and reruns the stride computation, a shift-add unit that
// takes one multiplier bit a cycle, so in_if.ready stays low after the write until the strides
// of all MAX_RANK axes are done. The length memory is not cleared: stepping through a batch
// whose length was never loaded gives an unspecified source index.
module reverse_sequence_address_gen_unit #(
  parameter int MAX_RANK  = rsag_pkg::MAX_RANK,
  parameter int BATCH_MAX = rsag_pkg::BATCH_MAX,
  parameter int DIM_W     = rsag_pkg::DIM_W,
  parameter int ADDR_W    = rsag_pkg::ADDR_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rsag_in_if.sink                           in_if,
  rsag_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [rsag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [DIM_W-1:0]                  cfg_wdata
);

  localparam int AXW = $clog2(MAX_RANK);
  localparam int DW2 = DIM_W + 2;
  localparam int CW  = 33;

  logic [MAX_RANK-1:0][DIM_W-1:0] dims;
  logic [MAX_RANK-1:0][DIM_W-1:0] digits;
  rsag_pkg::rsag_cfg_stat_t       stat;
  rsag_pkg::rsag_cnt_ctl_t        cnt_ctl;
  logic [ADDR_W-1:0]              seq_stride;
  logic [ADDR_W-1:0]              linear;
  logic                           all_wrap;
  logic                           load_err;
  logic [rsag_pkg::SLEN_W-1:0]    rd_len;
  logic                           hit;

  logic accept;
  logic seq_ok;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic rdy_o;

  // stage 1: request captured, length read in flight
  logic              v1_r;
  logic              step1_r;
  logic              err1_r;
  logic              last1_r;
  logic              seqv1_r;
  logic [ADDR_W-1:0] dst1_r;
  logic [DIM_W-1:0]  c1_r;
  logic [DIM_W-1:0]  size1_r;
  logic [ADDR_W-1:0] stride1_r;

  // stage 2: mirror offset
  logic                  v2_r;
  logic                  err2_r;
  logic                  last2_r;
  logic [ADDR_W-1:0]     dst2_r;
  logic [ADDR_W-1:0]     stride2_r;
  logic signed [DW2-1:0] d2_r;

  // stage 3: offset times stride
  logic              v3_r;
  logic              err3_r;
  logic              last3_r;
  logic [ADDR_W-1:0] dst3_r;
  logic [ADDR_W-1:0] prod3_r;

  // output register
  logic              ov_r;
  logic              oerr_r;
  logic              olast_r;
  logic [ADDR_W-1:0] odst_r;
  logic [ADDR_W-1:0] osrc_r;

  logic [rsag_pkg::SLEN_W-1:0] len_raw;
  logic [DIM_W-1:0]            len_sat;
  logic                        mirror;
  logic signed [DW2-1:0]       d_nxt;
  logic [ADDR_W-1:0]           d_ext;
  logic [ADDR_W-1:0]           prod_nxt;

  rsag_cfg #(
    .MAX_RANK (MAX_RANK),
    .DIM_W    (DIM_W),
    .ADDR_W   (ADDR_W)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .dims       (dims),
    .stat       (stat),
    .seq_stride (seq_stride)
  );

  assign cnt_ctl.clear = cfg_we;
  assign cnt_ctl.step  = accept && in_if.op == rsag_pkg::OP_STEP;

  rsag_cnt #(
    .MAX_RANK (MAX_RANK),
    .DIM_W    (DIM_W),
    .ADDR_W   (ADDR_W)
  ) u_cnt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cnt_ctl),
    .dims     (dims),
    .digits   (digits),
    .linear   (linear),
    .all_wrap (all_wrap)
  );

  rsag_len_tbl #(
    .MAX_RANK  (MAX_RANK),
    .BATCH_MAX (BATCH_MAX),
    .DIM_W     (DIM_W)
  ) u_len_tbl (
    .clk         (clk),
    .accept      (accept),
    .op          (in_if.op),
    .batch_index (in_if.batch_index),
    .seq_length  (in_if.seq_length),
    .dims        (dims),
    .digits      (digits),
    .stat        (stat),
    .load_err    (load_err),
    .rd_len_r    (rd_len),
    .hit_r       (hit)
  );

  // a stage advances when the one after it is empty or advancing
  assign rdy_o = !ov_r || out_if.ready;
  assign rdy3  = !v3_r || rdy_o;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;

  assign in_if.ready = rst_n && rdy1 && !stat.busy && !cfg_we;
  assign accept      = in_if.valid && in_if.ready;
  assign seq_ok      = int'(stat.seq_sel) < MAX_RANK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= accept;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy_o) ov_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step1_r   <= in_if.op == rsag_pkg::OP_STEP;
      err1_r    <= in_if.op == rsag_pkg::OP_LOAD && load_err;
      last1_r   <= in_if.op == rsag_pkg::OP_STEP && all_wrap;
      dst1_r    <= (in_if.op == rsag_pkg::OP_STEP) ? linear : '0;
      seqv1_r   <= seq_ok;
      c1_r      <= seq_ok ? digits[stat.seq_sel[AXW-1:0]] : '0;
      size1_r   <= seq_ok ? dims[stat.seq_sel[AXW-1:0]] : '0;
      stride1_r <= seq_stride;
    end
  end

  // source = destination + (len - 1 - 2c) * stride on the sequence axis when c < len
  always_comb begin
    len_raw = (seqv1_r && hit) ? rd_len : '0;
    len_sat = (CW'(len_raw) > CW'(size1_r)) ? size1_r : DIM_W'(len_raw);
    mirror  = step1_r && (c1_r < len_sat);
    d_nxt   = mirror ? signed'({2'b00, len_sat} - {1'b0, c1_r, 1'b0} - DW2'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      err2_r    <= err1_r;
      last2_r   <= last1_r;
      dst2_r    <= dst1_r;
      stride2_r <= stride1_r;
      d2_r      <= d_nxt;
    end
  end

  assign d_ext    = ADDR_W'(d2_r);
  assign prod_nxt = d_ext * stride2_r;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      err3_r  <= err2_r;
      last3_r <= last2_r;
      dst3_r  <= dst2_r;
      prod3_r <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && v3_r) begin
      oerr_r  <= err3_r;
      olast_r <= last3_r;
      odst_r  <= dst3_r;
      osrc_r  <= dst3_r + prod3_r;
    end
  end

  assign out_if.valid     = ov_r;
  assign out_if.dst_index = odst_r;
  assign out_if.src_index = osrc_r;
  assign out_if.last      = olast_r;
  assign out_if.error     = oerr_r;

endmodule

/* hdl/rsag_checker.sv */
// Port-level checks for the reverse-sequence address generator, bound to the top level.
`timescale 1ns / 1ps

module rsag_checker #(
  parameter int ADDR_W = rsag_pkg::ADDR_W
) (
  input logic              clk,
  input logic              rst_n,
  input logic              cfg_we,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] out_dst_index,
  input logic [ADDR_W-1:0] out_src_index,
  input logic              out_last,
  input logic              out_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dst_index) &&
      $stable(out_src_index) && $stable(out_last) && $stable(out_error))
    else $error("result changed while stalled");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("request taken while strides are recomputed");

  a_cfg_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !(in_valid && in_ready))
    else $error("request accepted with a configuration write");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_dst_index == '0 && out_src_index == '0 && !out_last)
    else $error("rejected load carries address fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind reverse_sequence_address_gen_unit rsag_checker #(
  .ADDR_W (ADDR_W)
) u_rsag_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .cfg_we        (cfg_we),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_dst_index (out_if.dst_index),
  .out_src_index (out_if.src_index),
  .out_last      (out_if.last),
  .out_error     (out_if.error)
);
